[design/iuhb_pkg.sv]
// Shared types and constants for the IPv4/UDP header builder.
// No dependencies; the other design files, apart from iuhb_if, refer to this package by scope.
`default_nettype none

package iuhb_pkg;

    // Item opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SRC_ADDR  = 3'd0;
    localparam logic [2:0] REG_DST_ADDR  = 3'd1;
    localparam logic [2:0] REG_SRC_PORT  = 3'd2;
    localparam logic [2:0] REG_DST_PORT  = 3'd3;
    localparam logic [2:0] REG_IDENT     = 3'd4;
    localparam logic [2:0] REG_FLAGS     = 3'd5;
    localparam logic [2:0] REG_TTL       = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_IDENT = 16'h1234;
    localparam logic [15:0] RST_FLAGS = 16'h8000;
    localparam logic [7:0]  RST_TTL   = 8'd64;

    // Header constants
    localparam logic [7:0]  C_VER_IHL     = 8'h45;
    localparam logic [7:0]  C_TOS         = 8'h00;
    localparam logic [7:0]  C_PROTO_UDP   = 8'd17;
    localparam logic [15:0] C_IP_HDR_LEN  = 16'd20;
    localparam logic [15:0] C_UDP_HDR_LEN = 16'd8;
    localparam logic [4:0]  C_HDR_LAST    = 5'd27;

    // Configuration values as seen by the datapath
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] ident;
        logic [15:0] flags_frag;
        logic [7:0]  ttl;
    } t_cfg;

    // Command passed from the classifier to the emitter
    typedef struct packed {
        logic        is_hdr;  // 1: emit a 28-byte header, 0: emit one payload byte
        logic        last;    // marks the final byte of the packet
        logic [15:0] len;     // payload length for a header command
        logic [7:0]  data;    // payload byte for a data command
    } t_cmd;

endpackage

`default_nettype wire

[design/iuhb_if.sv]
// Valid/ready channel interfaces for the header builder's input and output beats.
// No dependencies.
`default_nettype none

interface iuhb_item_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;

    modport source (output valid, output opcode, output payload_length,
                    output data_byte, input ready);
    modport sink   (input valid, input opcode, input payload_length,
                    input data_byte, output ready);
endinterface

interface iuhb_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[design/iuhb_regs.sv]
// APB configuration registers plus a registered partial checksum of the fixed header words.
// Depends on iuhb_pkg.
`default_nettype none

module iuhb_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [4:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output      logic [31:0]         prdata,
    output      logic                pready,
    output      iuhb_pkg::t_cfg      o_cfg,
    output      logic [18:0]         o_cfg_sum
);

    iuhb_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;
    logic [17:0]    r_sum_a;
    logic [17:0]    r_sum_b;
    logic [18:0]    r_cfg_sum;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_addr   <= '0;
            r_cfg.dst_addr   <= '0;
            r_cfg.src_port   <= '0;
            r_cfg.dst_port   <= '0;
            r_cfg.ident      <= iuhb_pkg::RST_IDENT;
            r_cfg.flags_frag <= iuhb_pkg::RST_FLAGS;
            r_cfg.ttl        <= iuhb_pkg::RST_TTL;
        end else if (wr_en) begin
            unique case (reg_idx)
                iuhb_pkg::REG_SRC_ADDR: r_cfg.src_addr   <= pwdata;
                iuhb_pkg::REG_DST_ADDR: r_cfg.dst_addr   <= pwdata;
                iuhb_pkg::REG_SRC_PORT: r_cfg.src_port   <= pwdata[15:0];
                iuhb_pkg::REG_DST_PORT: r_cfg.dst_port   <= pwdata[15:0];
                iuhb_pkg::REG_IDENT:    r_cfg.ident      <= pwdata[15:0];
                iuhb_pkg::REG_FLAGS:    r_cfg.flags_frag <= pwdata[15:0];
                iuhb_pkg::REG_TTL:      r_cfg.ttl        <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            iuhb_pkg::REG_SRC_ADDR: prdata = r_cfg.src_addr;
            iuhb_pkg::REG_DST_ADDR: prdata = r_cfg.dst_addr;
            iuhb_pkg::REG_SRC_PORT: prdata = {16'd0, r_cfg.src_port};
            iuhb_pkg::REG_DST_PORT: prdata = {16'd0, r_cfg.dst_port};
            iuhb_pkg::REG_IDENT:    prdata = {16'd0, r_cfg.ident};
            iuhb_pkg::REG_FLAGS:    prdata = {16'd0, r_cfg.flags_frag};
            iuhb_pkg::REG_TTL:      prdata = {24'd0, r_cfg.ttl};
            default:                prdata = '0;
        endcase
    end

    // Sum of the eight header words that do not depend on the length;
    // two register stages, settled well before any checksum byte goes out
    always_ff @(posedge i_clk) begin
        r_sum_a <= 18'({iuhb_pkg::C_VER_IHL, iuhb_pkg::C_TOS})
                 + 18'({r_cfg.ttl, iuhb_pkg::C_PROTO_UDP})
                 + 18'(r_cfg.ident)
                 + 18'(r_cfg.flags_frag);
        r_sum_b <= 18'(r_cfg.src_addr[31:16]) + 18'(r_cfg.src_addr[15:0])
                 + 18'(r_cfg.dst_addr[31:16]) + 18'(r_cfg.dst_addr[15:0]);
        r_cfg_sum <= 19'(r_sum_a) + 19'(r_sum_b);
    end

    assign o_cfg     = r_cfg;
    assign o_cfg_sum = r_cfg_sum;

endmodule

`default_nettype wire

[design/iuhb_front.sv]
// Input classifier: tracks packet state and turns accepted beats into emitter commands.
// Depends on iuhb_pkg and iuhb_if.
`default_nettype none

module iuhb_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    iuhb_item_if.sink            i_item,
    input  wire logic            i_full,
    output      logic            o_push,
    output      iuhb_pkg::t_cmd  o_cmd
);

    logic        r_in_packet;
    logic [15:0] r_bytes_left;
    logic        accept;
    logic        is_start;
    logic [15:0] left_dec;

    assign i_item.ready = !i_full;
    assign accept       = i_item.valid && !i_full;
    assign is_start     = (i_item.opcode == iuhb_pkg::OP_START);
    assign left_dec     = r_bytes_left - 16'd1;

    // Command build; data beats outside a packet are dropped
    always_comb begin
        o_push      = accept && (is_start || r_in_packet);
        o_cmd.is_hdr = is_start;
        o_cmd.len    = i_item.payload_length;
        o_cmd.data   = i_item.data_byte;
        o_cmd.last   = is_start ? (i_item.payload_length == 16'd0) : (left_dec == 16'd0);
    end

    // Packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet  <= 1'b0;
            r_bytes_left <= '0;
        end else if (accept) begin
            if (is_start) begin
                r_bytes_left <= i_item.payload_length;
                r_in_packet  <= (i_item.payload_length != 16'd0);
            end else if (r_in_packet) begin
                r_bytes_left <= left_dec;
                r_in_packet  <= (left_dec != 16'd0);
            end
        end
    end

endmodule

`default_nettype wire

[design/iuhb_fifo.sv]
// Short command queue between the classifier and the emitter, show-ahead head entry.
// Depends on iuhb_pkg.
`default_nettype none

module iuhb_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire iuhb_pkg::t_cmd  i_cmd,
    input  wire logic            i_pop,
    output      logic            o_full,
    output      logic            o_empty,
    output      iuhb_pkg::t_cmd  o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    iuhb_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/iuhb_back.sv]
// Emitter: serializes header commands into 28 bytes, passes payload bytes, owns the
// output register and the header checksum. Depends on iuhb_pkg and iuhb_if.
`default_nettype none

module iuhb_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire iuhb_pkg::t_cmd  i_cmd,
    input  wire logic            i_empty,
    output      logic            o_pop,
    input  wire iuhb_pkg::t_cfg  i_cfg,
    input  wire logic [18:0]     i_cfg_sum,
    iuhb_result_if.source        o_result
);

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_hdr_busy;
    logic [4:0]  r_idx;
    logic        r_hdr_last;
    logic [15:0] r_udp_len;
    logic [15:0] r_total;
    logic [19:0] r_sum;
    logic [15:0] r_csum;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic        adv;
    logic        step;
    logic [7:0]  hdr_byte;

    assign adv   = !r_out_valid || o_result.ready;
    assign step  = adv && r_hdr_busy;
    assign o_pop = adv && !r_hdr_busy && !i_empty;

    // Checksum: length-free words plus total length, folded twice, complemented
    assign fold1 = 17'(r_sum[15:0]) + 17'(r_sum[19:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    always_ff @(posedge i_clk) begin
        r_sum  <= 20'(i_cfg_sum) + 20'(r_total);
        r_csum <= ~fold2;
    end

    // Header byte select
    always_comb begin
        unique case (r_idx)
            5'd1:    hdr_byte = iuhb_pkg::C_TOS;
            5'd2:    hdr_byte = r_total[15:8];
            5'd3:    hdr_byte = r_total[7:0];
            5'd4:    hdr_byte = i_cfg.ident[15:8];
            5'd5:    hdr_byte = i_cfg.ident[7:0];
            5'd6:    hdr_byte = i_cfg.flags_frag[15:8];
            5'd7:    hdr_byte = i_cfg.flags_frag[7:0];
            5'd8:    hdr_byte = i_cfg.ttl;
            5'd9:    hdr_byte = iuhb_pkg::C_PROTO_UDP;
            5'd10:   hdr_byte = r_csum[15:8];
            5'd11:   hdr_byte = r_csum[7:0];
            5'd12:   hdr_byte = i_cfg.src_addr[31:24];
            5'd13:   hdr_byte = i_cfg.src_addr[23:16];
            5'd14:   hdr_byte = i_cfg.src_addr[15:8];
            5'd15:   hdr_byte = i_cfg.src_addr[7:0];
            5'd16:   hdr_byte = i_cfg.dst_addr[31:24];
            5'd17:   hdr_byte = i_cfg.dst_addr[23:16];
            5'd18:   hdr_byte = i_cfg.dst_addr[15:8];
            5'd19:   hdr_byte = i_cfg.dst_addr[7:0];
            5'd20:   hdr_byte = i_cfg.src_port[15:8];
            5'd21:   hdr_byte = i_cfg.src_port[7:0];
            5'd22:   hdr_byte = i_cfg.dst_port[15:8];
            5'd23:   hdr_byte = i_cfg.dst_port[7:0];
            5'd24:   hdr_byte = r_udp_len[15:8];
            5'd25:   hdr_byte = r_udp_len[7:0];
            default: hdr_byte = 8'h00;  // UDP checksum bytes and unused codes
        endcase
    end

    // Sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hdr_busy  <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= r_hdr_busy || !i_empty;
            end
            if (step) begin
                r_idx <= r_idx + 5'd1;
                if (r_idx == iuhb_pkg::C_HDR_LAST) begin
                    r_hdr_busy <= 1'b0;
                end
            end
            if (o_pop && i_cmd.is_hdr) begin
                r_hdr_busy <= 1'b1;
                r_idx      <= 5'd1;
            end
        end
    end

    // Output beat and per-packet lengths
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte <= hdr_byte;
            r_out_last <= (r_idx == iuhb_pkg::C_HDR_LAST) && r_hdr_last;
        end
        if (o_pop) begin
            if (i_cmd.is_hdr) begin
                r_out_byte <= iuhb_pkg::C_VER_IHL;
                r_out_last <= 1'b0;
                r_hdr_last <= i_cmd.last;
                r_udp_len  <= i_cmd.len + iuhb_pkg::C_UDP_HDR_LEN;
                r_total    <= i_cmd.len + iuhb_pkg::C_UDP_HDR_LEN + iuhb_pkg::C_IP_HDR_LEN;
            end else begin
                r_out_byte <= i_cmd.data;
                r_out_last <= i_cmd.last;
            end
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.out_byte  = r_out_byte;
    assign o_result.last_byte = r_out_last;

endmodule

`default_nettype wire

[design/ipv4_udp_header_builder.sv]
// Flow: a payload beat passes through the command queue and the output register; a start
// beat's first header byte takes the same path, followed by the other 27 header bytes.
// Throughput: one payload byte per cycle unless the output stalls; a start beat holds the
// emitter for all 28 header bytes; the queue (QUEUE_DEPTH entries) takes input until full.
// Reset (synchronous, active low): registers return to defaults, queue and packet state
// clear, output goes idle; no clearing pass.
`default_nettype none

module ipv4_udp_header_builder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    iuhb_item_if.sink        i_item,
    iuhb_result_if.source    o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    iuhb_pkg::t_cfg cfg;
    logic [18:0]    cfg_sum;
    iuhb_pkg::t_cmd push_cmd;
    iuhb_pkg::t_cmd head_cmd;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    iuhb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_cfg_sum (cfg_sum)
    );

    iuhb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    iuhb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    iuhb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_empty   (empty),
        .o_pop     (pop),
        .i_cfg     (cfg),
        .i_cfg_sum (cfg_sum),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

[design/iuhb_checker.sv]
// Port-level checks for the header builder, bound to the top level.
// Depends on iuhb_pkg and the top level ipv4_udp_header_builder.
`default_nettype none

module iuhb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last,
    input wire logic       i_psel,
    input wire logic       i_pready
);

    logic r_after_last;
    logic out_beat;

    assign out_beat = i_out_valid && i_out_ready;

    // Set after reset and after a last-marked beat; the next beat must open a header
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_last <= 1'b1;
        end else if (out_beat) begin
            r_after_last <= i_out_last;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("stalled output beat changed");

    a_header_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_after_last |-> i_out_byte == iuhb_pkg::C_VER_IHL)
        else $error("packet after idle does not open with version/IHL byte");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel |-> i_pready)
        else $error("config port inserted wait state");

endmodule

bind ipv4_udp_header_builder iuhb_checker u_iuhb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_byte  (o_result.out_byte),
    .i_out_last  (o_result.last_byte),
    .i_psel      (psel),
    .i_pready    (pready)
);

`default_nettype wire

[sim/ipv4_udp_header_builder_test.sv]
// Self-checking testbench for ipv4_udp_header_builder: drives start and payload beats,
// predicts the IPv4/UDP header bytes and payload stream, and checks every output beat.
// Depends on iuhb_pkg (design/iuhb_pkg.sv) and the channel interfaces in design/iuhb_if.sv.
`timescale 1ns / 1ps

module ipv4_udp_header_builder_test;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int WAIT_MAX      = 16;
    localparam int HDR_LEN       = 28;

    typedef struct {
        logic [7:0] value;
        logic       is_last;
    } t_packet_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    iuhb_item_if   item_ch ();
    iuhb_result_if result_ch ();

    ipv4_udp_header_builder uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow of the block: register file and packet state
    iuhb_pkg::t_cfg cfg_shadow;
    logic [15:0]    payload_left;
    logic           in_packet;
    t_packet_byte   expected_bytes[$];

    int fail_count;
    int cycle_count;
    int headers_sent;
    int payload_sent;
    int dropped_sent;
    int config_writes;
    int bytes_checked;
    int src_wait_max;
    int sink_wait_max;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes still due", cycle_count,
                     expected_bytes.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Header checksum: ones' complement sum of the nine header words, folded, inverted
    function automatic logic [15:0] header_checksum(input logic [15:0] ip_total);
        logic [31:0] sum;
        sum = 32'({iuhb_pkg::C_VER_IHL, iuhb_pkg::C_TOS}) + 32'(ip_total)
            + 32'(cfg_shadow.ident) + 32'(cfg_shadow.flags_frag)
            + 32'({cfg_shadow.ttl, iuhb_pkg::C_PROTO_UDP})
            + 32'(cfg_shadow.src_addr[31:16]) + 32'(cfg_shadow.src_addr[15:0])
            + 32'(cfg_shadow.dst_addr[31:16]) + 32'(cfg_shadow.dst_addr[15:0]);
        sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
        sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
        return ~sum[15:0];
    endfunction

    // Predict the output bytes of one accepted beat
    function automatic void model_encapsulation(input logic op, input logic [15:0] len,
                                                input logic [7:0] data);
        logic [15:0]   udp_len;
        logic [15:0]   ip_total;
        logic [223:0]  hdr;
        t_packet_byte  pb;
        if (op == iuhb_pkg::OP_START) begin
            udp_len  = iuhb_pkg::C_UDP_HDR_LEN + len;
            ip_total = iuhb_pkg::C_IP_HDR_LEN + udp_len;
            hdr = {iuhb_pkg::C_VER_IHL, iuhb_pkg::C_TOS, ip_total, cfg_shadow.ident,
                   cfg_shadow.flags_frag, cfg_shadow.ttl, iuhb_pkg::C_PROTO_UDP,
                   header_checksum(ip_total),
                   cfg_shadow.src_addr, cfg_shadow.dst_addr, cfg_shadow.src_port,
                   cfg_shadow.dst_port, udp_len, 16'd0};
            payload_left = len;
            in_packet    = (len != 16'd0);
            for (int i = 0; i < HDR_LEN; i++) begin
                pb.value   = hdr[223 - 8 * i -: 8];
                pb.is_last = (i == int'(iuhb_pkg::C_HDR_LAST)) && !in_packet;
                expected_bytes.push_back(pb);
            end
            headers_sent++;
        end else if (!in_packet) begin
            dropped_sent++;
        end else begin
            payload_left = payload_left - 16'd1;
            pb.value     = data;
            pb.is_last   = (payload_left == 16'd0);
            expected_bytes.push_back(pb);
            if (payload_left == 16'd0)
                in_packet = 1'b0;
            payload_sent++;
        end
    endfunction

    // Send one beat after a random gap; predict once it is taken
    task automatic send_beat(input logic op, input logic [15:0] len, input logic [7:0] data);
        int gap;
        gap = $urandom_range(0, src_wait_max);
        @(negedge i_clk);
        if (gap > 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid          = 1'b1;
        item_ch.opcode         = op;
        item_ch.payload_length = len;
        item_ch.data_byte      = data;
        do @(posedge i_clk); while (!item_ch.ready);
        model_encapsulation(op, len, data);
    endtask

    // Stop sending and wait until every predicted byte has come out
    task automatic wait_results_done();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    // Full quiesce before register access: drain, then let dropped beats clear
    task automatic quiesce();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] shadow_reg(input logic [2:0] idx);
        case (idx)
            iuhb_pkg::REG_SRC_ADDR: return cfg_shadow.src_addr;
            iuhb_pkg::REG_DST_ADDR: return cfg_shadow.dst_addr;
            iuhb_pkg::REG_SRC_PORT: return {16'd0, cfg_shadow.src_port};
            iuhb_pkg::REG_DST_PORT: return {16'd0, cfg_shadow.dst_port};
            iuhb_pkg::REG_IDENT:    return {16'd0, cfg_shadow.ident};
            iuhb_pkg::REG_FLAGS:    return {16'd0, cfg_shadow.flags_frag};
            iuhb_pkg::REG_TTL:      return {24'd0, cfg_shadow.ttl};
            default:                return 32'd0;
        endcase
    endfunction

    // APB write: setup then access; shadow updated at the completing edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            iuhb_pkg::REG_SRC_ADDR: cfg_shadow.src_addr   = value;
            iuhb_pkg::REG_DST_ADDR: cfg_shadow.dst_addr   = value;
            iuhb_pkg::REG_SRC_PORT: cfg_shadow.src_port   = value[15:0];
            iuhb_pkg::REG_DST_PORT: cfg_shadow.dst_port   = value[15:0];
            iuhb_pkg::REG_IDENT:    cfg_shadow.ident      = value[15:0];
            iuhb_pkg::REG_FLAGS:    cfg_shadow.flags_frag = value[15:0];
            iuhb_pkg::REG_TTL:      cfg_shadow.ttl        = value[7:0];
            default: ;
        endcase
        config_writes++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // APB read, compared against the shadow
    task automatic read_reg_check(input logic [2:0] idx);
        logic [31:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got !== shadow_reg(idx))
            report_mismatch($sformatf("reg %0d read 0x%08h, want 0x%08h",
                                      idx, got, shadow_reg(idx)));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Write all seven registers; mode 0 random, 1 all ones, 2 all zeros
    task automatic program_regs(input int mode);
        logic [31:0] value;
        for (int r = int'(iuhb_pkg::REG_SRC_ADDR); r <= int'(iuhb_pkg::REG_TTL); r++) begin
            case (mode)
                1:       value = 32'hFFFF_FFFF;
                2:       value = 32'h0;
                default: value = $urandom;
            endcase
            write_reg(3'(r), value);
        end
        for (int r = int'(iuhb_pkg::REG_SRC_ADDR); r <= int'(iuhb_pkg::REG_TTL); r++)
            read_reg_check(3'(r));
    endtask

    // Result side: random stall per beat, check each beat against the oldest expectation
    initial begin : result_sink
        int           stall;
        t_packet_byte want;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, sink_wait_max);
            if (stall > 0) begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && result_ch.valid));
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected beat 0x%02h last=%0b",
                                          result_ch.out_byte, result_ch.last_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (result_ch.out_byte !== want.value)
                    report_mismatch($sformatf("beat %0d out_byte 0x%02h, want 0x%02h",
                                              bytes_checked, result_ch.out_byte, want.value));
                if (result_ch.last_byte !== want.is_last)
                    report_mismatch($sformatf("beat %0d last_byte %0b, want %0b",
                                              bytes_checked, result_ch.last_byte,
                                              want.is_last));
            end
        end
    end

    // Reset values, empty packet with default header, payload while idle is dropped
    task automatic test_reset_defaults();
        for (int r = int'(iuhb_pkg::REG_SRC_ADDR); r <= int'(iuhb_pkg::REG_TTL); r++)
            read_reg_check(3'(r));
        send_beat(iuhb_pkg::OP_START, 16'd0, 8'hFF);
        send_beat(iuhb_pkg::OP_DATA, 16'hFFFF, 8'h00);
        send_beat(iuhb_pkg::OP_DATA, 16'h0000, 8'hFF);
        quiesce();
    endtask

    // Short packets with extreme payload bytes, back to back
    task automatic test_short_packets();
        src_wait_max = 0;
        send_beat(iuhb_pkg::OP_START, 16'd3, 8'h00);
        send_beat(iuhb_pkg::OP_DATA, 16'hFFFF, 8'h00);
        send_beat(iuhb_pkg::OP_DATA, 16'h0000, 8'hFF);
        send_beat(iuhb_pkg::OP_DATA, 16'h5A5A, 8'hA5);
        send_beat(iuhb_pkg::OP_START, 16'd1, 8'h5A);
        send_beat(iuhb_pkg::OP_DATA, 16'hA5A5, 8'h5A);
        src_wait_max = WAIT_MAX;
        quiesce();
    endtask

    // Lengths that wrap the header fields, and a start that abandons a packet
    task automatic test_oversized_and_restart();
        send_beat(iuhb_pkg::OP_START, 16'hFFFF, 8'h00);
        send_beat(iuhb_pkg::OP_DATA, 16'd0, 8'h81);
        send_beat(iuhb_pkg::OP_DATA, 16'd0, 8'h7E);
        send_beat(iuhb_pkg::OP_START, 16'd65507, 8'hFF);
        send_beat(iuhb_pkg::OP_DATA, 16'hFFFF, 8'h01);
        send_beat(iuhb_pkg::OP_DATA, 16'hFFFF, 8'h80);
        send_beat(iuhb_pkg::OP_START, 16'd0, 8'h00);
        quiesce();
    endtask

    // Register extremes: all ones, all zeros, then a mixed setting
    task automatic test_register_extremes();
        program_regs(1);
        send_beat(iuhb_pkg::OP_START, 16'd2, 8'h00);
        send_beat(iuhb_pkg::OP_DATA, 16'd0, 8'hFF);
        send_beat(iuhb_pkg::OP_DATA, 16'd0, 8'h00);
        quiesce();
        program_regs(2);
        send_beat(iuhb_pkg::OP_START, 16'd0, 8'h00);
        quiesce();
        program_regs(0);
        send_beat(iuhb_pkg::OP_START, 16'hFFF7, 8'h00);
        quiesce();
    endtask

    // Random packets: mostly complete ones, some cut short, some stray payload beats
    task automatic test_random_traffic(input int target);
        int          plan;
        int          n;
        logic [15:0] len;
        while (headers_sent + payload_sent < target) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0:       src_wait_max = 0;
                    1:       src_wait_max = 3;
                    default: src_wait_max = WAIT_MAX;
                endcase
                case ($urandom_range(0, 3))
                    0:       sink_wait_max = 0;
                    1:       sink_wait_max = 3;
                    default: sink_wait_max = WAIT_MAX;
                endcase
            end
            plan = $urandom_range(0, 19);
            if (plan < 2) begin
                send_beat(iuhb_pkg::OP_DATA, 16'($urandom), 8'($urandom));
            end else begin
                if ($urandom_range(0, 15) == 0)
                    len = 16'($urandom);
                else if ($urandom_range(0, 5) == 0)
                    len = 16'd0;
                else
                    len = 16'($urandom_range(1, 24));
                n = int'(len);
                if (plan < 5 || n > 40)
                    n = $urandom_range(0, (n > 40) ? 40 : n);
                send_beat(iuhb_pkg::OP_START, len, 8'($urandom));
                for (int i = 0; i < n; i++)
                    send_beat(iuhb_pkg::OP_DATA, 16'($urandom), 8'($urandom));
            end
            // occasional hold-off until the output is drained, then maybe a new setting
            if ($urandom_range(0, 24) == 0) begin
                wait_results_done();
                if (!in_packet && $urandom_range(0, 1) == 0) begin
                    repeat (SETTLE_CYCLES) @(posedge i_clk);
                    program_regs($urandom_range(0, 4) == 0 ? 1 : 0);
                end
            end
        end
        quiesce();
    endtask

    // Stimulus sequence
    initial begin
        i_rst_n                = 1'b0;
        item_ch.valid          = 1'b0;
        item_ch.opcode         = iuhb_pkg::OP_START;
        item_ch.payload_length = 16'd0;
        item_ch.data_byte      = 8'd0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = 5'd0;
        pwdata                 = 32'd0;
        cfg_shadow             = '{src_addr: 32'd0, dst_addr: 32'd0, src_port: 16'd0,
                                   dst_port: 16'd0, ident: iuhb_pkg::RST_IDENT,
                                   flags_frag: iuhb_pkg::RST_FLAGS,
                                   ttl: iuhb_pkg::RST_TTL};
        payload_left           = 16'd0;
        in_packet              = 1'b0;
        fail_count             = 0;
        cycle_count            = 0;
        headers_sent           = 0;
        payload_sent           = 0;
        dropped_sent           = 0;
        config_writes          = 0;
        bytes_checked          = 0;
        src_wait_max           = WAIT_MAX;
        sink_wait_max          = WAIT_MAX;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_short_packets();
        test_oversized_and_restart();
        test_register_extremes();
        test_random_traffic(headers_sent + payload_sent + 380);

        $display("Covered %0d headers, %0d payload bytes, %0d stray beats, %0d reg writes;",
                 headers_sent, payload_sent, dropped_sent, config_writes);
        $display("%0d output beats checked in %0d cycles.", bytes_checked, cycle_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
